### hw/rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// No dependencies; every other file imports this package.
`default_nettype none

package lrupr_pkg;

	// fixed field widths of the stream words
	localparam int PAGE_ID_W = 16;
	localparam int FRAME_W   = 4;
	localparam int COUNT_W   = 16;

	// parameter defaults
	localparam int FRAMES_DEF    = 4;
	localparam int PAGE_BITS_DEF = 16;

	// lookup decision handed from the lookup logic to the table
	typedef struct packed {
		logic               hit;    // page resident
		logic               evict;  // miss with a full table
		logic [FRAME_W-1:0] sel;    // frame hit or filled
	} lookup_t;

endpackage

`default_nettype wire

### hw/rtl/lrupr_req_if.sv
// Request channel: one page reference per word.
// Depends on lrupr_pkg.
`default_nettype none

interface lrupr_req_if import lrupr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PAGE_ID_W-1:0] page_id;

	modport source (output valid, output page_id, input ready);
	modport sink   (input valid, input page_id, output ready);
endinterface

`default_nettype wire

### hw/rtl/lrupr_rsp_if.sv
// Response channel: hit/fault result for each reference.
// Depends on lrupr_pkg.
`default_nettype none

interface lrupr_rsp_if import lrupr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 fault;
	logic [FRAME_W-1:0]   frame_used;
	logic                 evicted_valid;
	logic [PAGE_ID_W-1:0] evicted_page;
	logic [COUNT_W-1:0]   fault_total;

	modport source (output valid, output fault, output frame_used, output evicted_valid,
		output evicted_page, output fault_total, input ready);
	modport sink   (input valid, input fault, input frame_used, input evicted_valid,
		input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

### hw/rtl/lrupr_lookup.sv
// Parallel lookup over the frame table: hit search, first empty frame and
// oldest valid frame, combined into one decision. Depends on lrupr_pkg.
`default_nettype none

module lrupr_lookup import lrupr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic [FRAMES-1:0]         valid,
	input  wire logic [PAGE_BITS-1:0]      pages [FRAMES],
	input  wire logic [$clog2(FRAMES)-1:0] ranks [FRAMES],
	input  wire logic [PAGE_BITS-1:0]      page,
	output lookup_t                        dec
);
	localparam int IDX_W = $clog2(FRAMES);

	logic [FRAMES-1:0] match;
	logic [FRAMES-1:0] is_old;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  empty_idx;
	logic [IDX_W-1:0]  victim_idx;
	logic              full;
	logic [IDX_W-1:0]  sel_idx;

	// per-frame compare; a frame is oldest if no lower frame is as old and
	// no higher frame is older (ties go to the lower frame)
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			match[i]  = valid[i] && (pages[i] == page);
			is_old[i] = valid[i];
			for (int j = 0; j < FRAMES; j++) begin
				if (j < i && valid[j] && ranks[j] >= ranks[i]) begin
					is_old[i] = 1'b0;
				end
				if (j > i && valid[j] && ranks[j] > ranks[i]) begin
					is_old[i] = 1'b0;
				end
			end
		end
	end

	// priority pick: highest match, lowest empty, lowest oldest
	always_comb begin
		hit_idx    = '0;
		empty_idx  = '0;
		victim_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				empty_idx = IDX_W'(i);
			end
			if (is_old[i]) begin
				victim_idx = IDX_W'(i);
			end
		end
	end

	assign full    = &valid;
	assign sel_idx = (|match) ? hit_idx : (full ? victim_idx : empty_idx);

	always_comb begin
		dec.hit   = |match;
		dec.evict = !(|match) && full;
		dec.sel   = FRAME_W'(sel_idx);
	end

endmodule

`default_nettype wire

### hw/rtl/lrupr_table.sv
// Frame table state (valid, page, rank) plus fault counter, updated once per
// advancing reference. Depends on lrupr_pkg and lrupr_lookup.
`default_nettype none

module lrupr_table import lrupr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic [PAGE_BITS-1:0] page,
	output lookup_t                   dec,
	output logic      [PAGE_BITS-1:0] evict_page,
	output logic      [COUNT_W-1:0]   fault_total
);
	localparam int IDX_W  = $clog2(FRAMES);
	localparam int RANK_W = $clog2(FRAMES);

	logic [FRAMES-1:0]    valid_q;
	logic [PAGE_BITS-1:0] page_q [FRAMES];
	logic [RANK_W-1:0]    rank_q [FRAMES];
	logic [COUNT_W-1:0]   count_q;
	logic [IDX_W-1:0]     sel_idx;
	logic [RANK_W-1:0]    hit_rank;

	lrupr_lookup #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_lookup (
		.valid(valid_q),
		.pages(page_q),
		.ranks(rank_q),
		.page (page),
		.dec  (dec)
	);

	assign sel_idx    = dec.sel[IDX_W-1:0];
	assign hit_rank   = rank_q[sel_idx];
	assign evict_page = page_q[sel_idx];

	// saturating fault count, as reported with this word
	always_comb begin
		fault_total = count_q;
		if (!dec.hit && count_q != '1) begin
			fault_total = count_q + 1'b1;
		end
	end

	// valid marks, ranks and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (go) begin
			count_q <= fault_total;
			for (int i = 0; i < FRAMES; i++) begin
				if (IDX_W'(i) == sel_idx) begin
					rank_q[i] <= '0;
					valid_q[i] <= 1'b1;
				end else if (dec.hit) begin
					if (valid_q[i] && rank_q[i] < hit_rank) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end else if (valid_q[i] && rank_q[i] != RANK_W'(FRAMES - 1)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	// page numbers, written on a fill
	always_ff @(posedge clk) begin
		if (go && !dec.hit) begin
			page_q[sel_idx] <= page;
		end
	end

	a_evict_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		go && dec.evict |-> &valid_q)
		else $error("eviction with an empty frame available");

	a_fill_most_recent: assert property (@(posedge clk) disable iff (!arst_n)
		go && !dec.hit |=> valid_q[$past(sel_idx)] && rank_q[$past(sel_idx)] == '0)
		else $error("filled frame not valid and most recent");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("fault count went down");

endmodule

`default_nettype wire

### hw/rtl/lru_page_replacement.sv
// LRU page replacement table.
// Request channel (req): one page_id word per reference; only the low
// PAGE_BITS bits take part. Response channel (rsp): one word per reference
// with fault, frame_used, evicted_valid/evicted_page and the saturating
// fault_total including that reference.
// The page is registered on acceptance; once the result register is free or
// being read, the FRAMES-entry table is searched in parallel, updated, and
// the result registered. Throughput: one word per cycle while rsp is not
// held, set by the combined lookup and update of the frame table.
// Reset: all frames empty, ranks and fault count zero; no clearing pass.
// Stall: while rsp is held, req still takes a word into an empty input
// register, then req.ready drops until rsp.ready returns.
// Depends on lrupr_pkg, lrupr_req_if, lrupr_rsp_if, lrupr_table.
`default_nettype none

module lru_page_replacement import lrupr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	lrupr_req_if.sink  req,
	lrupr_rsp_if.source rsp
);
	logic                           v_s1;
	logic [PAGE_BITS-1:0]           page_s1;
	logic                           v_s2;
	logic                           fault_s2;
	logic [FRAME_W-1:0]             frame_s2;
	logic                           evict_s2;
	logic [PAGE_ID_W-1:0]           evpage_s2;
	logic [COUNT_W-1:0]             total_s2;
	logic                           adv;
	logic [PAGE_BITS+PAGE_ID_W-1:0] page_wide;
	logic [PAGE_ID_W+PAGE_BITS-1:0] evict_wide;
	lookup_t                        dec;
	logic [PAGE_BITS-1:0]           evict_page;
	logic [COUNT_W-1:0]             fault_total;

	assign adv       = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign page_wide = {{PAGE_BITS{1'b0}}, req.page_id};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			page_s1 <= page_wide[PAGE_BITS-1:0];
		end
	end

	lrupr_table #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (adv),
		.page       (page_s1),
		.dec        (dec),
		.evict_page (evict_page),
		.fault_total(fault_total)
	);

	assign evict_wide = {{PAGE_ID_W{1'b0}}, evict_page};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (rsp.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fault_s2  <= !dec.hit;
			frame_s2  <= dec.sel;
			evict_s2  <= dec.evict;
			evpage_s2 <= dec.evict ? evict_wide[PAGE_ID_W-1:0] : '0;
			total_s2  <= fault_total;
		end
	end

	assign rsp.valid         = v_s2;
	assign rsp.fault         = fault_s2;
	assign rsp.frame_used    = frame_s2;
	assign rsp.evicted_valid = evict_s2;
	assign rsp.evicted_page  = evpage_s2;
	assign rsp.fault_total   = total_s2;

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !fault_s2 |-> !evict_s2 && evpage_s2 == '0)
		else $error("hit word reports an eviction");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && fault_s2 |-> total_s2 != '0)
		else $error("fault word with zero fault total");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rsp.ready |-> !adv)
		else $error("result register overwritten while held");

endmodule

`default_nettype wire
